// File: hdl/rqp_pkg.sv
// Package for the radio RSSI query poller.
// Holds register indexes, reset values, reply byte codes and the configuration struct.
// No dependencies; rqp_cfg_regs, rqp_core and the top level refer to it by scoped names.
`default_nettype none

package rqp_pkg;

  // APB address width: three 32-bit registers at byte offsets 0, 4 and 8.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_QUERY_INTERVAL = 2'd0;
  localparam logic [1:0] REG_REPLY_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_PACKET_BYTES   = 2'd2;

  // Register reset values.
  localparam logic [15:0] QUERY_INTERVAL_RST = 16'd1500;
  localparam logic [15:0] REPLY_TIMEOUT_RST  = 16'd150;
  localparam logic [7:0]  PACKET_BYTES_RST   = 8'd48;

  // Fixed bytes of the four-byte RSSI reply.
  localparam logic [7:0] REPLY_HEAD  = 8'hC1;
  localparam logic [7:0] REPLY_ADDR  = 8'h00;
  localparam logic [7:0] REPLY_LEN   = 8'h01;
  localparam logic [7:0] REPLY_BYTES = 8'd4;

  // Configuration handed from the register block to the core.
  typedef struct packed {
    logic [15:0] query_interval_ms;
    logic [15:0] reply_timeout_ms;
    logic [7:0]  packet_bytes;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/rqp_if.sv
// Stream interfaces of the radio RSSI query poller: poll ticks in, status results out.
// Each carries valid, ready and its payload; a transfer happens when valid and ready are high.
// No dependencies.
`default_nettype none

interface rqp_poll_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [7:0]  rx_count;
  logic [7:0]  head_byte;
  logic [7:0]  reply_addr_byte;
  logic [7:0]  reply_len_byte;
  logic [7:0]  reply_rssi_byte;

  modport source (
    output valid, now_ms, rx_count, head_byte, reply_addr_byte, reply_len_byte,
           reply_rssi_byte,
    input  ready
  );
  modport sink (
    input  valid, now_ms, rx_count, head_byte, reply_addr_byte, reply_len_byte,
           reply_rssi_byte,
    output ready
  );
endinterface

interface rqp_status_if;
  logic              valid;
  logic              ready;
  logic              send_query;
  logic              consume_reply;
  logic signed [8:0] rssi_dbm;
  logic              rssi_ok;
  logic              awaiting_reply;

  modport source (
    output valid, send_query, consume_reply, rssi_dbm, rssi_ok, awaiting_reply,
    input  ready
  );
  modport sink (
    input  valid, send_query, consume_reply, rssi_dbm, rssi_ok, awaiting_reply,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/rqp_cfg_regs.sv
// APB configuration registers of the radio RSSI query poller.
// Depends on rqp_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module rqp_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rqp_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [rqp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [rqp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output rqp_pkg::cfg_t                          cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.query_interval_ms <= rqp_pkg::QUERY_INTERVAL_RST;
      cfg.reply_timeout_ms  <= rqp_pkg::REPLY_TIMEOUT_RST;
      cfg.packet_bytes      <= rqp_pkg::PACKET_BYTES_RST;
    end else if (wr_en) begin
      case (reg_index)
        rqp_pkg::REG_QUERY_INTERVAL: cfg.query_interval_ms <= pwdata[15:0];
        rqp_pkg::REG_REPLY_TIMEOUT:  cfg.reply_timeout_ms  <= pwdata[15:0];
        rqp_pkg::REG_PACKET_BYTES:   cfg.packet_bytes      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_index)
      rqp_pkg::REG_QUERY_INTERVAL: prdata = {16'd0, cfg.query_interval_ms};
      rqp_pkg::REG_REPLY_TIMEOUT:  prdata = {16'd0, cfg.reply_timeout_ms};
      rqp_pkg::REG_PACKET_BYTES:   prdata = {24'd0, cfg.packet_bytes};
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/rqp_core.sv
// Poll tick processing of the radio RSSI query poller: input register, state update and
// result register. Depends on rqp_pkg and on the rqp_poll_if and rqp_status_if interfaces.
`default_nettype none

module rqp_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rqp_pkg::cfg_t cfg,
  rqp_poll_if.sink           poll,
  rqp_status_if.source       status
);

  // Input register.
  logic        s1_valid;
  logic [31:0] s1_now;
  logic [7:0]  s1_count;
  logic [7:0]  s1_head;
  logic [7:0]  s1_addr;
  logic [7:0]  s1_len;
  logic [7:0]  s1_raw;
  logic        s1_advance;

  // Poller state. The last query time and the wait start time are always
  // loaded together, so a single register serves both.
  logic        waiting;
  logic        waiting_next;
  logic [31:0] query_time;
  logic [31:0] query_time_next;
  logic [8:0]  stored_rssi;
  logic [8:0]  stored_rssi_next;
  logic        stored_valid;
  logic        stored_valid_next;

  logic        send;
  logic        consume;
  logic [31:0] elapsed;
  logic        interval_done;
  logic        timed_out;

  // The input register moves on whenever the result register is free or being drained.
  assign s1_advance = s1_valid && (!status.valid || status.ready);
  assign poll.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_now   <= poll.now_ms;
      s1_count <= poll.rx_count;
      s1_head  <= poll.head_byte;
      s1_addr  <= poll.reply_addr_byte;
      s1_len   <= poll.reply_len_byte;
      s1_raw   <= poll.reply_rssi_byte;
    end
  end

  // Wrapping time difference and the two timer compares.
  assign elapsed       = s1_now - query_time;
  assign interval_done = elapsed >= {16'd0, cfg.query_interval_ms};
  assign timed_out     = elapsed > {16'd0, cfg.reply_timeout_ms};

  // Next state for one tick.
  always_comb begin
    waiting_next      = waiting;
    query_time_next   = query_time;
    stored_rssi_next  = stored_rssi;
    stored_valid_next = stored_valid;
    send              = 1'b0;
    consume           = 1'b0;
    if (!waiting) begin
      if (interval_done && (s1_count == 8'd0)) begin
        send            = 1'b1;
        query_time_next = s1_now;
        waiting_next    = 1'b1;
      end
    end else if (s1_count >= cfg.packet_bytes) begin
      waiting_next = 1'b0;
    end else if (s1_count >= rqp_pkg::REPLY_BYTES) begin
      if (s1_head == rqp_pkg::REPLY_HEAD) begin
        consume = 1'b1;
        if ((s1_addr == rqp_pkg::REPLY_ADDR) && (s1_len == rqp_pkg::REPLY_LEN)) begin
          // raw - 256 in 9-bit two's complement.
          stored_rssi_next  = {1'b1, s1_raw};
          stored_valid_next = 1'b1;
        end
      end
      waiting_next = 1'b0;
    end else if (timed_out) begin
      waiting_next = 1'b0;
    end
  end

  // State registers update once per tick as it leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting      <= 1'b0;
      query_time   <= '0;
      stored_rssi  <= '0;
      stored_valid <= 1'b0;
    end else if (s1_advance) begin
      waiting      <= waiting_next;
      query_time   <= query_time_next;
      stored_rssi  <= stored_rssi_next;
      stored_valid <= stored_valid_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (s1_advance) begin
      status.valid <= 1'b1;
    end else if (status.ready) begin
      status.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      status.send_query     <= send;
      status.consume_reply  <= consume;
      status.rssi_dbm       <= stored_rssi_next;
      status.rssi_ok        <= stored_valid_next;
      status.awaiting_reply <= waiting_next;
    end
  end

  // A query and a reply pop never come from the same tick.
  assert property (@(posedge clk) disable iff (rst)
    status.valid |-> !(status.send_query && status.consume_reply))
    else $error("send_query and consume_reply both set");

  // Sending a query always leaves the poller waiting.
  assert property (@(posedge clk) disable iff (rst)
    (status.valid && status.send_query) |-> status.awaiting_reply)
    else $error("query sent without entering the wait");

  // Popping a reply always ends the wait.
  assert property (@(posedge clk) disable iff (rst)
    (status.valid && status.consume_reply) |-> !status.awaiting_reply)
    else $error("reply consumed while still waiting");

  // Once a valid RSSI is stored it stays valid.
  assert property (@(posedge clk) disable iff (rst) !$fell(stored_valid))
    else $error("stored RSSI lost its valid bit");

  // A stored valid RSSI always has its sign bit set.
  assert property (@(posedge clk) disable iff (rst) stored_valid |-> stored_rssi[8])
    else $error("stored RSSI is not negative");

endmodule

`default_nettype wire

// File: hdl/radio_rssi_query_poller.sv
// Radio RSSI query poller, top level.
// Depends on rqp_pkg, rqp_if.sv (rqp_poll_if, rqp_status_if), rqp_cfg_regs and rqp_core.
//
// Usage: every poll tick enters on the poll channel with the current millisecond time
// and a snapshot of the UART receive FIFO (count, head byte and the next three bytes).
// For each tick exactly one result leaves on the status channel: send_query asks the
// UART to transmit the RSSI query, consume_reply asks it to pop four bytes, rssi_dbm and
// rssi_ok give the last stored RSSI, and awaiting_reply gives the state after the tick.
// The three configuration registers (query interval, reply timeout, packet size) sit on
// the APB port at byte offsets 0, 4 and 8; write them only while no tick is in flight.
// A poll transfer reaches its status result through the input register and then the
// result register. Throughput is one tick per cycle while results are taken; the
// single 32-bit subtract and its two compares sit between those registers.
// Reset clears the poller to idle with last query time 0, no stored RSSI, and loads the
// register defaults of 1500 ms, 150 ms and 48 bytes. When the status receiver stalls,
// the pending result holds, an empty input register still takes one more tick, and
// poll ready then drops until the result is taken.
`default_nettype none

module radio_rssi_query_poller (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rqp_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [rqp_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [rqp_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  rqp_poll_if.sink                            poll,
  rqp_status_if.source                        status
);

  rqp_pkg::cfg_t cfg;

  // Configuration registers.
  rqp_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Tick processing.
  rqp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .poll   (poll),
    .status (status)
  );

endmodule

`default_nettype wire
